// ===== src/rcrl_pkg.sv =====
// shared constants and types for the running rank tracker
package rcrl_pkg;

  localparam int CAPACITY = 1024;
  localparam int DATA_W   = 32;
  localparam int CNT_W    = 11;
  localparam int IDX_W    = CNT_W + 1;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int DIV_W    = CNT_W + 1;
  localparam int STEP_W   = $clog2(DIV_W + 1);

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;
  typedef logic [IDX_W-1:0]         idx_t;

endpackage

// ===== src/running_ceil_rank_largest_core.sv =====
// running rank tracker: dual heap in two memories under one sift sequencer
//
// Each accepted sample yields one result: the r-th largest sample so far, with
// r = ceil(count / rank_divisor) (a divisor of zero counts as one). The block
// takes one sample at a time and drops sample_ready until its result is
// loaded into the output register. Per sample it runs a 12-step serial divide
// for r, one heap insert and, where the rank grows, a pop from the lower heap
// and an insert into the upper heap. Per heap level a sift-down reads the left
// and right child and compares, and a sift-up checks and compares, all through
// the single read port of each heap memory. When a lowered divisor raises the
// rank by more than one, further roots are moved from the lower heap to the
// upper heap within that sample. After 1024 samples further samples are
// dropped and answered at once with overflow set. The heap memories need no
// clearing after reset.
module running_ceil_rank_largest_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  rcrl_pkg::cnt_t      cfg_data,
  input  logic                sample_valid,
  output logic                sample_ready,
  input  rcrl_pkg::data_t     sample_value,
  output logic                result_valid,
  input  logic                result_ready,
  output rcrl_pkg::data_t     rank_value,
  output rcrl_pkg::cnt_t      rank_in_use,
  output logic                overflow
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_DECIDE, S_PUSHOLD, S_MOVE, S_POP_R1, S_POP_R2, S_POP_R3,
    S_POP_PUSH, S_SD_RDL, S_SD_RDR, S_SD_CMP1, S_SD_CMP2, S_SU_CHK, S_SU_CMP,
    S_FINISH
  } state_t;

  state_t                        state, ret;
  rcrl_pkg::cnt_t                divisor, upper_count, lower_count, sample_count;
  rcrl_pkg::cnt_t                heap_n;
  rcrl_pkg::data_t               key, val, pending, lval, upper_root;
  rcrl_pkg::idx_t                idx;
  logic                          sel;
  logic                          ovf_flag;
  logic [rcrl_pkg::DIV_W-1:0]    div_num, div_rem, div_quo;
  logic [rcrl_pkg::STEP_W-1:0]   div_step;

  // heap memories, index i lives at address i-1
  rcrl_pkg::data_t mem_u [rcrl_pkg::CAPACITY];
  rcrl_pkg::data_t mem_l [rcrl_pkg::CAPACITY];
  rcrl_pkg::data_t rdata_u, rdata_l, rdata;

  logic            mem_rd, mem_we;
  rcrl_pkg::idx_t  rd_idx, wr_idx;
  rcrl_pkg::data_t wr_data;

  // min order for the upper heap, max order for the lower heap
  function automatic logic ahead(rcrl_pkg::data_t a, rcrl_pkg::data_t b, logic is_min);
    ahead = is_min ? (a < b) : (a > b);
  endfunction

  rcrl_pkg::cnt_t             d_eff;
  logic [rcrl_pkg::DIV_W-1:0] rem_sh;
  logic                       rem_ge;
  rcrl_pkg::idx_t             l_idx, r_idx, best_idx;
  rcrl_pkg::data_t            best_val;
  logic                       has_l, has_r, move_go, go_lower;

  assign rdata = sel ? rdata_u : rdata_l;
  assign d_eff = (divisor == '0) ? rcrl_pkg::cnt_t'(1) : divisor;
  assign rem_sh = {div_rem[rcrl_pkg::DIV_W-2:0], div_num[rcrl_pkg::DIV_W-1]};
  assign rem_ge = rem_sh >= {1'b0, d_eff};
  assign l_idx = {idx[rcrl_pkg::IDX_W-2:0], 1'b0};
  assign r_idx = l_idx + rcrl_pkg::idx_t'(1);
  assign has_l = l_idx <= {1'b0, heap_n};
  assign has_r = r_idx <= {1'b0, heap_n};
  assign move_go = ({1'b0, upper_count} < div_quo) && (lower_count != '0);
  assign go_lower = ({1'b0, upper_count} < div_quo) || (key < upper_root);

  // best of the travelling value and its children
  always_comb begin
    best_val = val;
    best_idx = idx;
    if (has_l && ahead(lval, best_val, sel)) begin
      best_val = lval;
      best_idx = l_idx;
    end
    if (has_r && ahead(rdata, best_val, sel)) begin
      best_val = rdata;
      best_idx = r_idx;
    end
  end

  // memory requests of the sequencer
  always_comb begin
    mem_rd  = 1'b0;
    mem_we  = 1'b0;
    rd_idx  = idx;
    wr_idx  = idx;
    wr_data = val;
    case (state)
      S_SD_RDL: begin
        if (has_l) begin
          mem_rd = 1'b1;
          rd_idx = l_idx;
        end else begin
          mem_we = 1'b1;
        end
      end
      S_SD_RDR: begin
        mem_rd = has_r;
        rd_idx = r_idx;
      end
      S_SD_CMP2: begin
        mem_we  = 1'b1;
        wr_data = best_val;
      end
      S_SU_CHK: begin
        if (idx == rcrl_pkg::idx_t'(1)) begin
          mem_we = 1'b1;
        end else begin
          mem_rd = 1'b1;
          rd_idx = idx >> 1;
        end
      end
      S_SU_CMP: begin
        mem_we = 1'b1;
        if (ahead(val, rdata, sel)) wr_data = rdata;
      end
      S_MOVE: begin
        mem_rd = move_go;
        rd_idx = rcrl_pkg::idx_t'(1);
      end
      S_POP_R1: begin
        mem_rd = 1'b1;
        rd_idx = {1'b0, lower_count};
      end
      default: ;
    endcase
  end

  // heap storage
  always_ff @(posedge clk) begin
    if (mem_we && sel) mem_u[rcrl_pkg::ADDR_W'(wr_idx - 1'b1)] <= wr_data;
    if (mem_we && !sel) mem_l[rcrl_pkg::ADDR_W'(wr_idx - 1'b1)] <= wr_data;
    if (mem_rd) begin
      rdata_u <= mem_u[rcrl_pkg::ADDR_W'(rd_idx - 1'b1)];
      rdata_l <= mem_l[rcrl_pkg::ADDR_W'(rd_idx - 1'b1)];
    end
  end

  // upper root mirror feeds the decision and the answer
  always_ff @(posedge clk) begin
    if (mem_we && sel && wr_idx == rcrl_pkg::idx_t'(1)) upper_root <= wr_data;
  end

  assign sample_ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ret          <= S_IDLE;
      divisor      <= rcrl_pkg::cnt_t'(1);
      upper_count  <= '0;
      lower_count  <= '0;
      sample_count <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_write) divisor <= cfg_data;
      if (result_valid && result_ready && state != S_FINISH) result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (sample_valid) begin
            key <= sample_value;
            if (sample_count >= rcrl_pkg::cnt_t'(rcrl_pkg::CAPACITY)) begin
              ovf_flag <= 1'b1;
              state    <= S_FINISH;
            end else begin
              ovf_flag     <= 1'b0;
              sample_count <= sample_count + 1'b1;
              div_num      <= {1'b0, sample_count} + {1'b0, d_eff};
              div_rem      <= '0;
              div_quo      <= '0;
              div_step     <= '0;
              state        <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_num  <= div_num << 1;
          div_rem  <= rem_ge ? rem_sh - {1'b0, d_eff} : rem_sh;
          div_quo  <= {div_quo[rcrl_pkg::DIV_W-2:0], rem_ge};
          div_step <= div_step + 1'b1;
          if (div_step == rcrl_pkg::STEP_W'(rcrl_pkg::DIV_W - 1)) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (go_lower) begin
            sel         <= 1'b0;
            lower_count <= lower_count + 1'b1;
            idx         <= {1'b0, lower_count} + 1'b1;
            val         <= key;
            ret         <= S_MOVE;
            state       <= S_SU_CHK;
          end else begin
            sel     <= 1'b1;
            pending <= upper_root;
            heap_n  <= upper_count;
            idx     <= rcrl_pkg::idx_t'(1);
            val     <= key;
            ret     <= S_PUSHOLD;
            state   <= S_SD_RDL;
          end
        end
        S_PUSHOLD: begin
          sel         <= 1'b0;
          lower_count <= lower_count + 1'b1;
          idx         <= {1'b0, lower_count} + 1'b1;
          val         <= pending;
          ret         <= S_MOVE;
          state       <= S_SU_CHK;
        end
        S_MOVE: begin
          sel   <= 1'b0;
          state <= move_go ? S_POP_R1 : S_FINISH;
        end
        // lower root arrives first, then the last entry
        S_POP_R1: begin
          pending <= rdata;
          state   <= S_POP_R2;
        end
        S_POP_R2: state <= S_POP_R3;
        S_POP_R3: begin
          val         <= rdata;
          lower_count <= lower_count - 1'b1;
          heap_n      <= lower_count - 1'b1;
          idx         <= rcrl_pkg::idx_t'(1);
          ret         <= S_POP_PUSH;
          state       <= S_SD_RDL;
        end
        S_POP_PUSH: begin
          sel         <= 1'b1;
          upper_count <= upper_count + 1'b1;
          idx         <= {1'b0, upper_count} + 1'b1;
          val         <= pending;
          ret         <= S_MOVE;
          state       <= S_SU_CHK;
        end
        S_SD_RDL: state <= has_l ? S_SD_RDR : ret;
        S_SD_RDR: begin
          lval  <= rdata;
          state <= S_SD_CMP1;
        end
        S_SD_CMP1: state <= S_SD_CMP2;
        S_SD_CMP2: begin
          if (best_idx == idx) begin
            state <= ret;
          end else begin
            idx   <= best_idx;
            state <= S_SD_RDL;
          end
        end
        S_SU_CHK: state <= (idx == rcrl_pkg::idx_t'(1)) ? ret : S_SU_CMP;
        S_SU_CMP: begin
          if (ahead(val, rdata, sel)) begin
            idx   <= idx >> 1;
            state <= S_SU_CHK;
          end else begin
            state <= ret;
          end
        end
        S_FINISH: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            rank_value   <= (upper_count != '0) ? upper_root : '0;
            rank_in_use  <= upper_count;
            overflow     <= ovf_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/rcrl_checker.sv =====
// port-level checks for the running rank tracker, bound to the top level
module rcrl_checker (
  input logic            clk,
  input logic            rst,
  input logic            sample_valid,
  input logic            sample_ready,
  input logic            result_valid,
  input logic            result_ready,
  input rcrl_pkg::data_t rank_value,
  input rcrl_pkg::cnt_t  rank_in_use,
  input logic            overflow
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(rank_value)
      && $stable(rank_in_use) && $stable(overflow))
    else $error("stalled result changed");

  // an accepted sample always leaves a nonempty upper heap
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !overflow |-> rank_in_use != '0)
    else $error("result with zero rank");

  // one sample at a time
  assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> !sample_ready)
    else $error("second sample taken while busy");

  // reset empties the output register
  assert property (@(posedge clk) $past(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind running_ceil_rank_largest_core rcrl_checker u_rcrl_checker (
  .clk(clk), .rst(rst), .sample_valid(sample_valid), .sample_ready(sample_ready),
  .result_valid(result_valid), .result_ready(result_ready),
  .rank_value(rank_value), .rank_in_use(rank_in_use), .overflow(overflow)
);

// ===== dv/running_ceil_rank_largest_core_tb.sv =====
// self-checking testbench for the running rank tracker
`timescale 1ns / 100ps

module running_ceil_rank_largest_core_tb;

  typedef struct packed {
    rcrl_pkg::data_t value;
    rcrl_pkg::cnt_t  rank;
    logic            ovf;
  } rank_result_t;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            cfg_write = 1'b0;
  rcrl_pkg::cnt_t  cfg_data = '0;
  logic            sample_valid = 1'b0;
  logic            sample_ready;
  rcrl_pkg::data_t sample_value = '0;
  logic            result_valid;
  logic            result_ready = 1'b0;
  rcrl_pkg::data_t rank_value;
  rcrl_pkg::cnt_t  rank_in_use;
  logic            overflow;

  // predictor state: heaps 1-based, plain signed compare
  rcrl_pkg::data_t upper_q[$];
  rcrl_pkg::data_t lower_q[$];
  int    taken;
  int    divisor_shadow;

  rcrl_pkg::data_t sample_fifo[$];
  rank_result_t    expected_q[$];
  int           errors = 0;
  int           results_seen = 0;
  int           overflows_seen = 0;
  longint       cycle_count = 0;
  int           hold_off = 0;
  bit           long_stall_req = 1'b0;
  int           send_gap = 0;
  int           recv_gap = 0;

  running_ceil_rank_largest_core i_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_ready(sample_ready),
    .sample_value(sample_value),
    .result_valid(result_valid), .result_ready(result_ready),
    .rank_value(rank_value), .rank_in_use(rank_in_use), .overflow(overflow)
  );

  always #5 clk = ~clk;

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // heap helpers; is_min selects upper (min) or lower (max) order
  function automatic bit ahead(rcrl_pkg::data_t a, rcrl_pkg::data_t b, bit is_min);
    return is_min ? (a < b) : (a > b);
  endfunction

  task automatic heap_sift_down(ref rcrl_pkg::data_t h[$], input bit is_min);
    int i, l, r, best, n;
    rcrl_pkg::data_t t;
    n = h.size() - 1;
    i = 1;
    forever begin
      best = i; l = 2 * i; r = l + 1;
      if (l <= n && ahead(h[l], h[best], is_min)) best = l;
      if (r <= n && ahead(h[r], h[best], is_min)) best = r;
      if (best == i) break;
      t = h[i]; h[i] = h[best]; h[best] = t;
      i = best;
    end
  endtask

  task automatic heap_push(ref rcrl_pkg::data_t h[$], input rcrl_pkg::data_t v,
                           input bit is_min);
    int i, p;
    rcrl_pkg::data_t t;
    h.push_back(v);
    i = h.size() - 1;
    while (i > 1) begin
      p = i / 2;
      if (!ahead(h[i], h[p], is_min)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endtask

  task automatic heap_pop(ref rcrl_pkg::data_t h[$], input bit is_min,
                          output rcrl_pkg::data_t v);
    v = h[1];
    h[1] = h[h.size() - 1];
    void'(h.pop_back());
    heap_sift_down(h, is_min);
  endtask

  // compute the expected rank result for one accepted sample
  task automatic predict_rank(input rcrl_pkg::data_t s);
    int d, r;
    rcrl_pkg::data_t v;
    rank_result_t res;
    res.ovf = 1'b0;
    if (taken >= rcrl_pkg::CAPACITY) begin
      res.ovf = 1'b1;
    end else begin
      d = (divisor_shadow == 0) ? 1 : divisor_shadow;
      taken++;
      r = (taken + d - 1) / d;
      if (upper_q.size() - 1 < r || s < upper_q[1]) begin
        heap_push(lower_q, s, 1'b0);
      end else begin
        heap_push(lower_q, upper_q[1], 1'b0);
        upper_q[1] = s;
        heap_sift_down(upper_q, 1'b1);
      end
      while (upper_q.size() - 1 < r && lower_q.size() > 1) begin
        heap_pop(lower_q, 1'b0, v);
        heap_push(upper_q, v, 1'b1);
      end
    end
    res.value = (upper_q.size() > 1) ? upper_q[1] : '0;
    res.rank  = rcrl_pkg::cnt_t'(upper_q.size() - 1);
    expected_q.push_back(res);
  endtask

  // driver: offers queued samples with random gaps
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) begin
        predict_rank(sample_value);
        void'(sample_fifo.pop_front());
        send_gap = gap_len();
      end
      if ((!sample_valid || sample_ready) && send_gap > 0) begin
        send_gap--;
        sample_valid <= 1'b0;
      end else if (!sample_valid || sample_ready) begin
        if (sample_fifo.size() > 0) begin
          sample_valid <= 1'b1;
          sample_value <= sample_fifo[0];
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transfer against the oldest expectation
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (result_valid && result_ready) begin
        rank_result_t e;
        results_seen++;
        if (expected_q.size() == 0) begin
          $error("result transfer with no expectation waiting");
          errors++;
        end else begin
          e = expected_q.pop_front();
          if (overflow) overflows_seen++;
          if (rank_value !== e.value) begin
            $error("rank_value exp %0d got %0d", e.value, rank_value);
            errors++;
          end
          if (rank_in_use !== e.rank) begin
            $error("rank_in_use exp %0d got %0d", e.rank, rank_in_use);
            errors++;
          end
          if (overflow !== e.ovf) begin
            $error("overflow exp %0d got %0d", e.ovf, overflow);
            errors++;
          end
        end
      end
      // receiver stall: long hold-off on request, else random gaps
      if (long_stall_req && hold_off == 0) begin
        hold_off = 400;
        long_stall_req = 1'b0;
        result_ready <= 1'b0;
      end else if (hold_off > 0) begin
        hold_off--;
        result_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap = gap_len();
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    if (cycle_count > 600000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic rcrl_pkg::data_t rand_sample(int mode);
    case (mode)
      0: return rcrl_pkg::data_t'($urandom);
      1: return rcrl_pkg::data_t'($urandom_range(0, 15)) - 8;
      default: return rcrl_pkg::data_t'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic wait_drained();
    while (sample_fifo.size() > 0 || sample_valid || expected_q.size() > 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic set_divisor(input int d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= rcrl_pkg::cnt_t'(d);
    divisor_shadow = d;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int mode;
    int phase_div[6];
    upper_q = '{0};
    lower_q = '{0};
    taken = 0;
    divisor_shadow = 1;
    phase_div = '{2, 1024, 1, 7, 2, 1};
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, ties, divisor zero then normal
    set_divisor(0);
    sample_fifo.push_back(32'sh7fffffff);
    sample_fifo.push_back(32'sh80000000);
    sample_fifo.push_back(32'sh80000000);
    sample_fifo.push_back(0);
    sample_fifo.push_back(-1);
    sample_fifo.push_back(32'sh55555555);
    sample_fifo.push_back(32'shaaaaaaaa);
    sample_fifo.push_back(32'sh7fffffff);
    wait_drained();

    set_divisor(3);
    for (int i = 0; i < 12; i++) sample_fifo.push_back(rand_sample(i % 3));
    wait_drained();

    // divisor above the range and the top bit of the field
    set_divisor(2047);
    for (int i = 0; i < 30; i++) sample_fifo.push_back(rand_sample(0));
    long_stall_req = 1'b1;
    for (int i = 0; i < 60; i++) sample_fifo.push_back(rand_sample(1));
    wait_drained();

    // random phases across divisors, raised and lowered mid-stream
    foreach (phase_div[k]) begin
      set_divisor(phase_div[k]);
      for (int i = 0; i < 100; i++) begin
        mode = $urandom_range(0, 2);
        sample_fifo.push_back(rand_sample(mode));
      end
      wait_drained();
    end

    // short tail of full-range samples
    for (int i = 0; i < 20; i++) sample_fifo.push_back(rand_sample(0));
    wait_drained();

    $display("covered %0d results, %0d overflow drops, divisors 0..2047",
             results_seen, overflows_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
